// ----- hw/rtl/mrbrh_pkg.sv -----
// Shared types and constants of the multi-resolution byte-rate history block.
// Used by mrbrh_ticks and multi_resolution_byte_rate_history; depends on nothing.
package mrbrh_pkg;

  // Sizes of the interface table and the history ring.
  localparam int unsigned NumIfaces = 8;
  localparam int unsigned NumRes    = 4;
  localparam int unsigned HistDepth = 1024;

  // Field widths.
  localparam int unsigned IfaceW  = 3;
  localparam int unsigned ResW    = 2;
  localparam int unsigned SlotW   = $clog2(HistDepth);
  localparam int unsigned PeriodW = 17;
  localparam int unsigned CountW  = 64;
  localparam int unsigned CfgIdxW = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned InBits   = IfaceW + 2 * CountW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = IfaceW + ResW + SlotW + 2 * CountW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Register reset values.
  localparam logic [PeriodW-1:0] Period1Reset = PeriodW'(60);
  localparam logic [PeriodW-1:0] Period2Reset = PeriodW'(3600);
  localparam logic [PeriodW-1:0] Period3Reset = PeriodW'(86400);

  // Resolution 0 records on every tick.
  localparam logic [PeriodW-1:0] FinestPeriod = PeriodW'(1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriod1 = 2'd0,
    CfgPeriod2 = 2'd1,
    CfgPeriod3 = 2'd2
  } cfg_idx_e;

  // Item kinds carried in tuser.
  typedef enum logic {
    OpPrime  = 1'b0,
    OpSample = 1'b1
  } op_e;

  // Periods of all resolutions, indexed by resolution.
  typedef logic [NumRes-1:0][PeriodW-1:0] period_vec_t;

endpackage

// ----- hw/rtl/mrbrh_ticks.sv -----
// Shared tick counters, one per resolution, and the due mask derived from them.
// Depends on mrbrh_pkg.
module mrbrh_ticks
  import mrbrh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  period_vec_t          period_i,
  output logic [NumRes-1:0]    due_o
);

  logic [NumRes-1:0][PeriodW-1:0] tick_q, tick_d;

  // A resolution is due while its counter stands at zero.
  always_comb begin
    for (int r = 0; r < NumRes; r++) begin
      due_o[r] = (tick_q[r] == '0);
    end
  end

  // Increment, clearing on reaching the period or on wrapping.
  always_comb begin
    logic [PeriodW-1:0] t;
    t = '0;
    tick_d = tick_q;
    for (int r = 0; r < NumRes; r++) begin
      t = tick_q[r] + PeriodW'(1);
      if (t >= period_i[r] || t == '0) begin
        t = '0;
      end
      if (advance_i) begin
        tick_d[r] = t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else begin
      tick_q <= tick_d;
    end
  end

endmodule

// ----- hw/rtl/multi_resolution_byte_rate_history.sv -----
// Top level of the multi-resolution byte-rate history block.
// Depends on mrbrh_pkg and mrbrh_ticks.
//
// Each sample transfer for an interface below NumIfaces yields one record for
// every resolution whose tick counter is zero, lowest resolution first, with
// tlast on the final record; a prime transfer loads the previous values of its
// interface and yields nothing. An accepted item enters a work register and
// its records leave through a single output register at one record per cycle
// while the output is not held off; an item yields 0 to 4 records, and a prime
// item or a sample with nothing due leaves the work stage without a record.
// Back-pressure on the output stalls the work stage record by record. The first
// record passes through the work register and then the output register. Tick
// counters advance when a sample marked with tlast enters the work stage. Periods
// are written through the configuration channel, which is always ready; the user
// must write them only while the block is idle; the block does not enforce it.
module multi_resolution_byte_rate_history
  import mrbrh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [PeriodW-1:0]    cfg_data_i,

  // Input stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata from bit 0: iface[2:0], rx_count[66:3], tx_count[130:67], zero pad.
  input  logic [InDataW-1:0]    s_axis_tdata_i,
  // tuser: operation.
  input  logic                  s_axis_tuser_i,
  // tlast: end_of_tick.
  input  logic                  s_axis_tlast_i,

  // Output stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata from bit 0: out_iface[2:0], resolution[4:3], slot[14:5],
  // rx_delta[78:15], tx_delta[142:79], zero pad.
  output logic [OutDataW-1:0]   m_axis_tdata_o,
  // tlast: last record of the sample.
  output logic                  m_axis_tlast_o
);

  // Input field views.
  logic [IfaceW-1:0] in_iface;
  logic [CountW-1:0] in_rx, in_tx;
  op_e               in_op;

  assign in_iface = s_axis_tdata_i[IfaceW-1:0];
  assign in_rx    = s_axis_tdata_i[IfaceW +: CountW];
  assign in_tx    = s_axis_tdata_i[IfaceW+CountW +: CountW];
  assign in_op    = op_e'(s_axis_tuser_i);

  // Configuration registers.
  logic [PeriodW-1:0] period1_q, period2_q, period3_q;
  period_vec_t        periods;

  assign cfg_ready_o = 1'b1;
  assign periods     = {period3_q, period2_q, period1_q, FinestPeriod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period1_q <= Period1Reset;
      period2_q <= Period2Reset;
      period3_q <= Period3Reset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPeriod1: period1_q <= cfg_data_i;
        CfgPeriod2: period2_q <= cfg_data_i;
        CfgPeriod3: period3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Work stage.
  logic                 work_valid_q;
  op_e                  work_op_q;
  logic [IfaceW-1:0]    work_iface_q;
  logic [CountW-1:0]    work_rx_q, work_tx_q;
  logic [NumRes-1:0]    work_mask_q;

  logic                 in_xfer;
  logic                 in_range;
  logic                 advance;
  logic [NumRes-1:0]    due;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = {1'b0, in_iface} < (IfaceW + 1)'(NumIfaces);
  assign advance  = in_xfer && (in_op == OpSample) && s_axis_tlast_i;

  mrbrh_ticks u_ticks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .period_i  (periods),
    .due_o     (due)
  );

  // Per-interface state, one row of four resolutions per interface.
  logic [CountW-1:0] prev_rx_q  [NumIfaces][NumRes];
  logic [CountW-1:0] prev_tx_q  [NumIfaces][NumRes];
  logic [SlotW-1:0]  wr_slot_q  [NumIfaces][NumRes];

  // Pick the lowest pending resolution.
  logic [ResW-1:0]   sel;
  logic [NumRes-1:0] mask_next;

  always_comb begin
    sel = '0;
    for (int r = NumRes - 1; r >= 0; r--) begin
      if (work_mask_q[r]) begin
        sel = ResW'(r);
      end
    end
    mask_next      = work_mask_q;
    mask_next[sel] = 1'b0;
  end

  // Record for the selected resolution.
  logic              out_free;
  logic              emit;
  logic              work_done;
  logic [SlotW-1:0]  cur_slot, new_slot;
  logic [CountW-1:0] rx_delta, tx_delta;

  assign out_free  = !m_axis_tvalid_o || m_axis_tready_i;
  assign emit      = work_valid_q && (work_op_q == OpSample) && (work_mask_q != '0)
                     && out_free;
  assign work_done = work_valid_q && ((work_op_q == OpPrime) || (work_mask_q == '0)
                     || (emit && (mask_next == '0)));
  assign s_axis_tready_o = !work_valid_q || work_done;

  assign cur_slot = wr_slot_q[work_iface_q][sel];
  assign new_slot = (cur_slot == SlotW'(HistDepth - 1)) ? '0 : cur_slot + SlotW'(1);
  assign rx_delta = work_rx_q - prev_rx_q[work_iface_q][sel];
  assign tx_delta = work_tx_q - prev_tx_q[work_iface_q][sel];

  // Work register: load a new item or step through its pending resolutions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      work_mask_q  <= '0;
    end else if (in_xfer) begin
      work_valid_q <= 1'b1;
      work_mask_q  <= (in_op == OpSample && in_range) ? due : '0;
    end else if (work_done) begin
      work_valid_q <= 1'b0;
      work_mask_q  <= '0;
    end else if (emit) begin
      work_mask_q  <= mask_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      work_op_q    <= in_op;
      work_iface_q <= in_iface;
      work_rx_q    <= in_rx;
      work_tx_q    <= in_tx;
    end
  end

  // State update: priming loads the previous counts of a whole row, a record updates one entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumIfaces; i++) begin
        for (int r = 0; r < NumRes; r++) begin
          prev_rx_q[i][r] <= '0;
          prev_tx_q[i][r] <= '0;
          wr_slot_q[i][r] <= '0;
        end
      end
    end else if (work_valid_q && work_op_q == OpPrime
                 && {1'b0, work_iface_q} < (IfaceW + 1)'(NumIfaces)) begin
      for (int r = 0; r < NumRes; r++) begin
        prev_rx_q[work_iface_q][r] <= work_rx_q;
        prev_tx_q[work_iface_q][r] <= work_tx_q;
      end
    end else if (emit) begin
      prev_rx_q[work_iface_q][sel] <= work_rx_q;
      prev_tx_q[work_iface_q][sel] <= work_tx_q;
      wr_slot_q[work_iface_q][sel] <= new_slot;
    end
  end

  // Output register.
  logic                out_valid_q;
  logic                out_last_q;
  logic [OutBits-1:0]  out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {tx_delta, rx_delta, new_slot, sel, work_iface_q};
      out_last_q <= (mask_next == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - OutBits)'(0), out_data_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
